FILE: design/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store
// holds request/status codes, cell row commands and fixed field widths
// no dependencies
package pls_pkg;

    // fixed field widths
    localparam int POS_W       = 5;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;

    // request operation codes
    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // command to the cell row for one transaction
    typedef enum logic [1:0] {
        ROW_HOLD   = 2'd0,
        ROW_WRITE  = 2'd1,
        ROW_INSERT = 2'd2,
        ROW_REMOVE = 2'd3
    } t_row_op;

endpackage

FILE: design/pls_if.sv
// pls_if: valid/ready channel interfaces for requests and responses
// depends on pls_pkg for field widths
interface pls_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic [pls_pkg::POS_W-1:0]         position;
    logic signed [pls_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pls_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pls_pkg::DATA_W-1:0]      read_value;
    logic [1:0]                             status;
    logic [pls_pkg::COUNT_OUT_W-1:0]        entry_count;
    logic                                   is_empty;

    modport source (output valid, output read_value, output status, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    input is_empty, output ready);
endinterface

FILE: design/pls_cell_row.sv
// pls_cell_row: row of list cells that shift up or down in parallel
// depends on pls_pkg for the row command type and data width
module pls_cell_row #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  pls_pkg::t_row_op                  i_cmd,
    input  logic [$clog2(CAPACITY)-1:0]       i_index,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    input  logic signed [pls_pkg::DATA_W-1:0] i_value,
    output logic signed [pls_pkg::DATA_W-1:0] o_rd_data
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [pls_pkg::DATA_W-1:0] r_cell [CAPACITY];
    logic [CW:0] idx_ext;
    logic [CW:0] cnt_ext;

    assign idx_ext = (CW+1)'(i_index);
    assign cnt_ext = (CW+1)'(i_count);

    // read port at the addressed position
    assign o_rd_data = r_cell[i_index];

    // one register per cell, each sees only its neighbors
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [CW:0] CELL_K  = (CW+1)'(k);
        localparam logic [CW:0] CELL_K1 = (CW+1)'(k + 1);
        logic signed [pls_pkg::DATA_W-1:0] w_below;
        logic signed [pls_pkg::DATA_W-1:0] w_above;
        logic signed [pls_pkg::DATA_W-1:0] n_cell;

        if (k > 0) begin : g_below
            assign w_below = r_cell[k-1];
        end else begin : g_no_below
            assign w_below = '0;
        end

        if (k < CAPACITY - 1) begin : g_above
            assign w_above = r_cell[k+1];
        end else begin : g_no_above
            assign w_above = '0;
        end

        // next value for this cell
        always_comb begin
            n_cell = r_cell[k];
            unique case (i_cmd)
                pls_pkg::ROW_HOLD: begin
                    n_cell = r_cell[k];
                end
                pls_pkg::ROW_WRITE: begin
                    if (CELL_K == idx_ext) n_cell = i_value;
                end
                pls_pkg::ROW_INSERT: begin
                    if (CELL_K == idx_ext) begin
                        n_cell = i_value;
                    end else if (CELL_K > idx_ext && CELL_K <= cnt_ext) begin
                        n_cell = w_below;
                    end
                end
                pls_pkg::ROW_REMOVE: begin
                    if (CELL_K >= idx_ext && CELL_K1 < cnt_ext) n_cell = w_above;
                end
                default: n_cell = r_cell[k];
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_cell[k] <= n_cell;
        end
    end

endmodule

FILE: design/positional_list_store.sv
// positional_list_store: ordered list of signed values addressed by 1-based position
// a request is registered in the input stage, and its response in the result stage
// throughput: one request per cycle while responses are not stalled; all cells shift in parallel
// reset (synchronous, active low) empties the list and drops both pipeline stages
// cell contents are not cleared and read only after being written
// depends on pls_pkg, pls_if and pls_cell_row
module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pls_req_if.sink       i_req,
    pls_rsp_if.source     o_rsp
);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;

    // input register stage
    logic                              r_in_valid;
    pls_pkg::t_op                      r_op;
    logic [pls_pkg::POS_W-1:0]         r_pos;
    logic signed [pls_pkg::DATA_W-1:0] r_value;

    // list state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // result register stage
    logic                              r_out_valid;
    logic signed [pls_pkg::DATA_W-1:0] r_read_value;
    pls_pkg::t_status                  r_status;
    logic [pls_pkg::COUNT_OUT_W-1:0]   r_entry_count;
    logic                              r_is_empty;

    logic                              accept_in;
    logic                              advance;
    logic [CMP_W-1:0]                  pos_ext;
    logic [CMP_W-1:0]                  cnt_ext;
    logic [CMP_W-1:0]                  pos_m1;
    logic [CMP_W-1:0]                  cnt_next_ext;
    logic                              bad_pos;
    logic                              is_full;
    pls_pkg::t_status                  status;
    pls_pkg::t_row_op                  row_cmd;
    logic signed [pls_pkg::DATA_W-1:0] rd_data;
    logic signed [pls_pkg::DATA_W-1:0] read_value;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign accept_in   = i_req.valid && i_req.ready;

    // position checks against the current count
    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign is_full = (cnt_ext == CMP_W'(CAPACITY));

    // decode the request into status, row command and new count
    always_comb begin
        status       = pls_pkg::ST_OK;
        row_cmd      = pls_pkg::ROW_HOLD;
        cnt_next_ext = cnt_ext;
        read_value   = '0;
        bad_pos      = 1'b0;
        unique case (r_op)
            pls_pkg::OP_INSERT: begin
                bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
                if (bad_pos) begin
                    status = pls_pkg::ST_BAD_POS;
                end else if (is_full) begin
                    status = pls_pkg::ST_FULL;
                end else begin
                    row_cmd      = pls_pkg::ROW_INSERT;
                    cnt_next_ext = cnt_ext + CMP_W'(1);
                end
            end
            pls_pkg::OP_GET: begin
                bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
                if (bad_pos) status = pls_pkg::ST_BAD_POS;
                else         read_value = rd_data;
            end
            pls_pkg::OP_SET: begin
                bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
                if (bad_pos) status = pls_pkg::ST_BAD_POS;
                else         row_cmd = pls_pkg::ROW_WRITE;
            end
            pls_pkg::OP_REMOVE: begin
                bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
                if (bad_pos) begin
                    status = pls_pkg::ST_BAD_POS;
                end else begin
                    row_cmd      = pls_pkg::ROW_REMOVE;
                    cnt_next_ext = cnt_ext - CMP_W'(1);
                end
            end
            default: status = pls_pkg::ST_BAD_POS;
        endcase
        // cells only move when the transaction advances
        if (!advance) row_cmd = pls_pkg::ROW_HOLD;
    end

    assign n_count = cnt_next_ext[CW-1:0];

    // list cells
    pls_cell_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .i_clk     (i_clk),
        .i_cmd     (row_cmd),
        .i_index   (pos_m1[IW-1:0]),
        .i_count   (r_count),
        .i_value   (r_value),
        .o_rd_data (rd_data)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_op    <= pls_pkg::t_op'(i_req.op);
            r_pos   <= i_req.position;
            r_value <= i_req.value;
        end
    end

    // count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (advance) begin
            r_count <= n_count;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_value  <= read_value;
            r_status      <= status;
            r_entry_count <= cnt_next_ext[pls_pkg::COUNT_OUT_W-1:0];
            r_is_empty    <= (cnt_next_ext == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;
    assign o_rsp.is_empty    = r_is_empty;

endmodule

FILE: design/pls_checker.sv
// pls_checker: port-level assertions for positional_list_store
// depends on pls_pkg; attached to the top level by the bind below
module pls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic signed [pls_pkg::DATA_W-1:0] i_rsp_read_value,
    input logic [1:0]                        i_rsp_status,
    input logic [pls_pkg::COUNT_OUT_W-1:0]   i_rsp_entry_count
);

    // no response right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // a stalled response stays up
    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // a failed request reads back zero
    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != pls_pkg::ST_OK) |-> i_rsp_read_value == '0)
        else $error("failed request returned data");

    // a full status only appears with a nonzero count
    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == pls_pkg::ST_FULL) |-> i_rsp_entry_count != '0
            || i_rsp_status != pls_pkg::ST_FULL)
        else $error("list full reported on an empty list");

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_read_value  (o_rsp.read_value),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_count (o_rsp.entry_count)
);
